>>> design/olar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olar_pkg: shared definitions for the ordered list block
// Capacity, counter widths and result status codes.
// ----------------------------------------------------------------------------
package olar_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;

    typedef logic [CNT_W-1:0] count_t;
    typedef logic [VAL_W-1:0] value_t;

    localparam logic [1:0] ST_APPENDED = 2'd0;
    localparam logic [1:0] ST_REMOVED  = 2'd1;
    localparam logic [1:0] ST_NOMATCH  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef struct packed {
        logic occupied;
        logic load_key;
        logic shift_en;
        logic tail_sel;
        logic hit_en;
    } cell_ctrl_t;

endpackage

>>> design/olar_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olar_cell: one storage cell of the ordered list
// Holds one entry, compares it against the search key and takes the value of
// its upper neighbor when the list closes a gap.
// ----------------------------------------------------------------------------
module olar_cell
    import olar_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  value_t     key,
    input  value_t     nbr_value,
    output value_t     value,
    output logic       hit,
    output value_t     tail_tap
);

    value_t value_reg;
    value_t value_next;
    logic   hit_reg;
    logic   hit_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.load_key)
        begin
            value_next = key;
        end
        else if (ctrl.shift_en)
        begin
            value_next = nbr_value;
        end
    end

    always_comb
    begin
        hit_next = hit_reg;
        if (ctrl.hit_en)
        begin
            hit_next = ctrl.occupied && (value_reg == key);
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign value    = value_reg;
    assign hit      = hit_reg;
    assign tail_tap = ctrl.tail_sel ? value_reg : '0;

endmodule

>>> design/ordered_list_append_remove_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_append_remove_top: bounded ordered list of signed values
// A row of cells holds the list with the head in cell zero.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_ready) carries one request per
//   transaction: req_type selects append at the tail or removal of the first
//   entry, counting from the head, that equals item_value.
//   The output channel (out_valid / out_ready) carries one result per request
//   with the status, head and tail values, entry count and empty flag as the
//   list stands after that request.
//   A request is captured at an accepting edge; the sequencer then steps
//   through compare, update and report states and takes no new request
//   until it is back in idle: all cells compare against the key, the cells
//   shift, and the result is assembled. The result sits in an output
//   register, so the next request is accepted while a result still waits; a
//   stall on the output only blocks the block once the following result is
//   ready and the register is still full.
//   Reset empties the list and drops any pending result; cell contents are
//   not cleared.
// ----------------------------------------------------------------------------
module ordered_list_append_remove_top
    import olar_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              req_type,
    input  logic signed [31:0] item_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic signed [31:0] head_value,
    output logic signed [31:0] tail_value,
    output logic [4:0]        entry_count,
    output logic              list_empty
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_MATCH  = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;
    localparam logic [1:0] S_REPORT = 2'd3;

    logic [1:0]  state_reg;
    logic [1:0]  state_next;
    count_t      count_reg;
    count_t      count_next;
    logic        op_reg;
    value_t      key_reg;
    logic [1:0]  st_reg;
    logic [1:0]  st_next;
    logic        ovalid_reg;
    logic        ovalid_next;
    logic [1:0]  ostatus_reg;
    value_t      ohead_reg;
    value_t      otail_reg;
    count_t      ocount_reg;

    value_t                 values [CAPACITY];
    value_t                 taps   [CAPACITY];
    logic [CAPACITY-1:0]    hits;
    logic [CAPACITY-1:0]    from_first;
    logic                   found;
    logic                   accept;
    logic                   out_load;
    logic                   can_append;
    value_t                 tail_sum;

    assign accept     = in_valid && in_ready;
    assign in_ready   = (state_reg == S_IDLE);
    assign out_load   = (state_reg == S_REPORT) && (!ovalid_reg || out_ready);
    assign found      = |hits;
    assign from_first = hits | ((~hits) + CAPACITY'(1));
    assign can_append = (count_reg != count_t'(CAPACITY));

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            value_t     nbr;
            cell_ctrl_t ctrl;
            if (g == CAPACITY - 1)
            begin : g_last
                assign nbr = '0;
            end
            else
            begin : g_mid
                assign nbr = values[g+1];
            end

            always_comb
            begin
                ctrl.occupied = (count_t'(g) < count_reg);
                ctrl.hit_en   = (state_reg == S_MATCH);
                ctrl.load_key = (state_reg == S_UPDATE) && (op_reg == REQ_APPEND)
                                && (count_reg == count_t'(g));
                ctrl.shift_en = (state_reg == S_UPDATE) && (op_reg == REQ_REMOVE)
                                && from_first[g];
                ctrl.tail_sel = (count_reg == count_t'(g + 1));
            end

            olar_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .key       (key_reg),
                .nbr_value (nbr),
                .value     (values[g]),
                .hit       (hits[g]),
                .tail_tap  (taps[g])
            );
        end
    endgenerate

    always_comb
    begin
        tail_sum = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            tail_sum = tail_sum | taps[i];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        st_next    = st_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                state_next = S_REPORT;
                if (op_reg == REQ_APPEND)
                begin
                    if (can_append)
                    begin
                        count_next = count_reg + count_t'(1);
                        st_next    = ST_APPENDED;
                    end
                    else
                    begin
                        st_next = ST_FULL;
                    end
                end
                else
                begin
                    if (found)
                    begin
                        count_next = count_reg - count_t'(1);
                        st_next    = ST_REMOVED;
                    end
                    else
                    begin
                        st_next = ST_NOMATCH;
                    end
                end
            end
            S_REPORT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (out_load)
        begin
            ovalid_next = 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
        if (accept)
        begin
            op_reg  <= req_type;
            key_reg <= value_t'(item_value);
        end
        if (out_load)
        begin
            ostatus_reg <= st_reg;
            ohead_reg   <= (count_reg != '0) ? values[0] : '0;
            otail_reg   <= tail_sum;
            ocount_reg  <= count_reg;
        end
    end

    assign out_valid   = ovalid_reg;
    assign status      = ostatus_reg;
    assign head_value  = ohead_reg;
    assign tail_value  = otail_reg;
    assign entry_count = 5'(ocount_reg);
    assign list_empty  = (ocount_reg == '0);

endmodule

>>> design/olar_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olar_checker: port-level checks for the ordered list block
// Watches the top level's channels and result fields over time.
// ----------------------------------------------------------------------------
module olar_checker
    import olar_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [31:0] head_value,
    input logic [31:0] tail_value,
    input logic [4:0]  entry_count,
    input logic        list_empty
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on consecutive cycles");

    a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && list_empty |-> head_value == '0 && tail_value == '0)
        else $error("empty list reports nonzero head or tail");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> entry_count == 5'(CAPACITY) && !list_empty)
        else $error("dropped append while list not full");

    a_single_head_tail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && entry_count == 5'd1 |-> head_value == tail_value)
        else $error("single entry with differing head and tail");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(head_value) && $stable(status))
        else $error("stalled result changed");

endmodule

bind ordered_list_append_remove_top olar_checker u_olar_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .head_value  (head_value),
    .tail_value  (tail_value),
    .entry_count (entry_count),
    .list_empty  (list_empty)
);

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for ordered_list_append_remove_top
// A directed sequence covers the empty list, extreme values, a full list with
// a dropped append and duplicate removal. Random append and remove traffic
// then fills and drains the list under varying stalls on both channels. A
// list model in the bench predicts every result, and each result is compared
// field by field in order.
// ----------------------------------------------------------------------------
module testbench
    import olar_pkg::*;
;

    typedef struct packed {
        logic [1:0] status;
        value_t     head;
        value_t     tail;
        logic [4:0] count;
        logic       empty;
    } list_view_t;

    logic               clk;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic               req_type   = REQ_APPEND;
    logic signed [31:0] item_value = '0;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic [1:0]         status;
    logic signed [31:0] head_value;
    logic signed [31:0] tail_value;
    logic [4:0]         entry_count;
    logic               list_empty;

    value_t     list_cells [CAPACITY];
    int         list_len      = 0;
    list_view_t pending_views[$];
    int         src_idle_pct  = 0;
    int         snk_idle_pct  = 0;
    int         fail_count    = 0;
    int         checked_count = 0;
    int         append_count  = 0;
    int         remove_count  = 0;
    int         full_count    = 0;
    int         miss_count    = 0;

    ordered_list_append_remove_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .item_value  (item_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .head_value  (head_value),
        .tail_value  (tail_value),
        .entry_count (entry_count),
        .list_empty  (list_empty)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic list_view_t apply_request(input logic kind, input value_t val);
        list_view_t view;
        int         hit;
        hit = -1;
        if (kind == REQ_APPEND)
        begin
            if (list_len >= CAPACITY)
            begin
                view.status = ST_FULL;
            end
            else
            begin
                list_cells[list_len] = val;
                list_len++;
                view.status = ST_APPENDED;
            end
        end
        else
        begin
            view.status = ST_NOMATCH;
            for (int i = 0; i < list_len; i++)
            begin
                if (hit < 0 && list_cells[i] == val)
                    hit = i;
            end
            if (hit >= 0)
            begin
                for (int j = hit; j < list_len - 1; j++)
                    list_cells[j] = list_cells[j + 1];
                list_len--;
                view.status = ST_REMOVED;
            end
        end
        view.empty = (list_len == 0);
        view.count = list_len[4:0];
        if (list_len == 0)
        begin
            view.head = '0;
            view.tail = '0;
        end
        else
        begin
            view.head = list_cells[0];
            view.tail = list_cells[list_len - 1];
        end
        return view;
    endfunction

    task automatic send_request(input logic kind, input value_t val);
        list_view_t view;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= kind;
        item_value <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        view = apply_request(kind, val);
        pending_views.push_back(view);
        case (view.status)
            ST_APPENDED: append_count++;
            ST_REMOVED:  remove_count++;
            ST_FULL:     full_count++;
            default:     miss_count++;
        endcase
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_views.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        list_view_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_views.size() == 0)
            begin
                $display("%0t ns: result with none expected, actual status %0d head %h tail %h",
                         $time, status, head_value, tail_value);
                fail_count++;
            end
            else
            begin
                want = pending_views.pop_front();
                checked_count++;
                check_field("status", want.status, status);
                check_field("head_value", want.head, head_value);
                check_field("tail_value", want.tail, tail_value);
                check_field("entry_count", want.count, entry_count);
                check_field("list_empty", want.empty, list_empty);
            end
        end
    end

    task automatic test_empty_list();
        send_request(REQ_REMOVE, 32'd5);
    endtask

    task automatic test_extreme_values();
        send_request(REQ_APPEND, 32'h7FFF_FFFF);
        send_request(REQ_APPEND, 32'h8000_0000);
        send_request(REQ_APPEND, 32'h0000_0000);
        send_request(REQ_APPEND, 32'hFFFF_FFFF);
    endtask

    task automatic test_full_list();
        for (int i = 0; i < CAPACITY - 4; i++)
        begin
            if (i % 4 == 0)
                send_request(REQ_APPEND, 32'd5);
            else
                send_request(REQ_APPEND, value_t'(i * 1000 - 6000));
        end
        send_request(REQ_APPEND, 32'd42);
    endtask

    task automatic test_removal_cases();
        send_request(REQ_REMOVE, 32'd5);
        send_request(REQ_REMOVE, 32'h7FFF_FFFF);
        send_request(REQ_REMOVE, 32'd1234);
        send_request(REQ_REMOVE, list_cells[list_len - 1]);
        send_request(REQ_REMOVE, 32'h8000_0000);
    endtask

    task automatic test_random_traffic(input int n_items, input int src_pct, input int snk_pct);
        logic   kind;
        value_t val;
        bit     growing;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        growing = 1'b1;
        for (int k = 0; k < n_items; k++)
        begin
            if (list_len >= CAPACITY && $urandom_range(2) != 0)
                growing = 1'b0;
            if (list_len == 0 && $urandom_range(2) != 0)
                growing = 1'b1;
            if ($urandom_range(31) == 0)
                growing = !growing;
            kind = ($urandom_range(99) < (growing ? 20 : 80)) ? REQ_REMOVE : REQ_APPEND;
            if (kind == REQ_REMOVE && list_len > 0 && $urandom_range(99) < 75)
                val = list_cells[$urandom_range(list_len - 1)];
            else if ($urandom_range(1) == 0)
                val = value_t'(int'($urandom_range(7)) - 4);
            else if ($urandom_range(9) == 0)
                val = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            else
                val = $urandom();
            send_request(kind, val);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_extreme_values();
        test_full_list();
        test_removal_cases();
        test_random_traffic(450, 10, 75);
        wait_for_results();
        test_random_traffic(450, 75, 10);
        wait_for_results();
        test_random_traffic(450, 0, 0);
        wait_for_results();
        repeat (16) @(posedge clk);
        $display("Checked %0d results: %0d appends, %0d removals, %0d dropped at full,",
                 checked_count, append_count, remove_count, full_count);
        $display("and %0d removals without a match, under three stall mixes.", miss_count);
        if (fail_count == 0 && pending_views.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results outstanding.", pending_views.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
